// ----- src/trc_pkg.sv -----
package trc_pkg;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_READ  = 6'b001000,
      ST_EXEC  = 6'b010000,
      ST_CLEAR = 6'b100000
   } state_type;

   localparam logic [1:0] CSR_LPR     = 2'd0;
   localparam logic [1:0] CSR_FILTER  = 2'd1;
   localparam logic [1:0] CSR_CNT_OFF = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT = 2'd3;

   localparam logic OP_CLASSIFY = 1'b0;
   localparam logic OP_TIMEOUT  = 1'b1;

   localparam logic [16:0] IDX_CONTROL = 17'h1FFFF;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request word
      logic sess_clear; // session change
      logic scan_rst;   // start cache scan
      logic scan_step;  // compare one entry
      logic hit_read;   // issue read of the hit entry
      logic exec;       // do the update and present the result
      logic clr_step;   // clear one valid bit
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic sess_diff;
      logic is_timeout;
      logic scan_done;
      logic hit;
      logic clr_done;
   } sts_type;

endpackage

// ----- src/trc_ctrl.sv -----
module trc_ctrl
   import trc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output logic    busy,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.sess_diff) begin
               cmd.sess_clear = 1'b1;
            end
            cmd.scan_rst = 1'b1;
            if (sts.is_timeout) begin
               state_in = ST_EXEC;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.hit) begin
               cmd.hit_read = 1'b1;
               state_in     = ST_READ;
            end else if (sts.scan_done) begin
               state_in = ST_EXEC;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/trc_dp.sv -----
module trc_dp
   import trc_pkg::*;
#(
   parameter int CACHE_DEPTH = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        req_op,
   input  logic [31:0] req_session,
   input  logic [15:0] req_trigger_seq,
   input  logic [62:0] req_time_ns,
   input  logic        csr_we,
   input  logic [1:0]  csr_idx,
   input  logic [63:0] csr_data,
   output logic        rsp_valid,
   output logic [31:0] rsp_round_generation,
   output logic        rsp_decision,
   output logic signed [16:0] rsp_logical_index,
   output logic        rsp_new_distinct,
   output logic        rsp_round_complete,
   output logic        rsp_final_logical,
   output logic        rsp_timeout_closed,
   output logic [62:0] rsp_idle_ns,
   output logic [31:0] rsp_completed_physical,
   output logic [7:0]  rsp_completed_filtered,
   output logic        rsp_round_state
);

   localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
   localparam int CW = $clog2(CACHE_DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(CACHE_DEPTH - 1);
   localparam int DW = 32 + 1 + 17 + 1;

   // config
   logic [15:0] lpr_ff;
   logic [7:0]  filt_ff;
   logic        cnt_off_ff;
   logic [47:0] tmo_ff;

   // round state
   logic [31:0] sess_ff, gen_ff, phys_ff, lphys_ff;
   logic [15:0] lcnt_ff;
   logic [7:0]  fcnt_ff, lfilt_ff;
   logic [62:0] anchor_ff;
   logic        anchor_v_ff, mode_ff;

   // request word
   logic        op_ff;
   logic [31:0] rsess_ff;
   logic [15:0] seq_ff;
   logic [62:0] t_ff;

   // cache
   logic [CACHE_DEPTH-1:0] valid_ff;
   logic [15:0]   key_mem [CACHE_DEPTH];
   logic [DW-1:0] dec_mem [CACHE_DEPTH];
   logic [AW-1:0] head_ff, ptr_ff, clr_ff;
   logic [CW-1:0] left_ff;
   logic [15:0]   key_rd_ff;
   logic          key_v_ff, rd_v_ff;
   logic [DW-1:0] dec_rd_ff;
   logic          hit_ff;

   function automatic logic [AW-1:0] dec_ptr(input logic [AW-1:0] p);
      return (p == '0) ? LAST : p - AW'(1);
   endfunction

   function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
      return (p == LAST) ? '0 : p + AW'(1);
   endfunction

   // combinational compare of the registered entry read last cycle
   logic cmp_hit;
   assign cmp_hit = rd_v_ff && key_v_ff && (key_rd_ff == seq_ff);

   assign sts.sess_diff  = (rsess_ff != sess_ff);
   assign sts.is_timeout = (op_ff == OP_TIMEOUT);
   assign sts.hit        = cmp_hit;
   assign sts.scan_done  = (left_ff == '0) && !rd_v_ff;
   assign sts.clr_done   = (clr_ff == LAST);

   // update logic
   logic [31:0] gen_n, phys_n, lphys_n;
   logic [15:0] lcnt_n;
   logic [7:0]  fcnt_n, lfilt_n;
   logic [62:0] anchor_n, gap, idle_n;
   logic        anchor_v_n, mode_n, tc_n, rc_n, fin_n, dec_n;
   logic [16:0] idx_n;

   always_comb begin
      gen_n = gen_ff; phys_n = phys_ff; lphys_n = lphys_ff;
      lcnt_n = lcnt_ff; fcnt_n = fcnt_ff; lfilt_n = lfilt_ff;
      anchor_n = anchor_ff; anchor_v_n = anchor_v_ff; mode_n = mode_ff;
      tc_n = 1'b0; rc_n = 1'b0; fin_n = 1'b0; dec_n = 1'b0;
      idx_n = '0; idle_n = '0;
      gap = t_ff - anchor_ff;
      if (op_ff == OP_TIMEOUT) begin
         if (phys_ff != '0) begin
            lphys_n = phys_ff; lfilt_n = fcnt_ff;
            phys_n = '0; lcnt_n = '0; fcnt_n = '0;
            anchor_n = '0; anchor_v_n = 1'b0; mode_n = (filt_ff == '0);
            gen_n = gen_ff + 32'd1;
            tc_n = 1'b1;
         end
      end else begin
         if (phys_ff != '0 && tmo_ff != '0 && anchor_v_ff && t_ff >= anchor_ff
             && gap >= {15'd0, tmo_ff}) begin
            idle_n = gap; tc_n = 1'b1;
            lphys_n = phys_ff; lfilt_n = fcnt_ff;
            phys_n = '0; lcnt_n = '0; fcnt_n = '0;
            anchor_n = '0; anchor_v_n = 1'b0; mode_n = (filt_ff == '0);
            gen_n = gen_ff + 32'd1;
         end
         if (phys_n != '1) begin
            phys_n = phys_n + 32'd1;
         end
         if (t_ff != '0 && (!anchor_v_n || t_ff >= anchor_n)) begin
            anchor_n = t_ff; anchor_v_n = 1'b1;
         end
         if (fcnt_n < filt_ff) begin
            idx_n  = IDX_CONTROL;
            fcnt_n = fcnt_n + 8'd1;
            mode_n = !(fcnt_n < filt_ff);
         end else begin
            dec_n = 1'b1;
            idx_n = {1'b0, lcnt_n};
            if (lcnt_n != '1) begin
               lcnt_n = lcnt_n + 16'd1;
            end
            if (!cnt_off_ff && lcnt_n == lpr_ff) begin
               rc_n = 1'b1; fin_n = 1'b1;
               lphys_n = phys_n; lfilt_n = fcnt_n;
               phys_n = '0; lcnt_n = '0; fcnt_n = '0;
               anchor_n = '0; anchor_v_n = 1'b0; mode_n = (filt_ff == '0);
               gen_n = gen_n + 32'd1;
            end
         end
      end
   end

   logic [31:0] gen_out;
   assign gen_out = (op_ff == OP_TIMEOUT) ? gen_n : gen_ff + 32'(tc_n);

   // cache arrays
   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[ptr_ff];
      dec_rd_ff <= dec_mem[ptr_ff];
      if (cmd.exec && !hit_ff && op_ff == OP_CLASSIFY) begin
         key_mem[head_ff] <= seq_ff;
         dec_mem[head_ff] <= {gen_out, dec_n, idx_n, fin_n};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lpr_ff <= 16'd1; filt_ff <= '0; cnt_off_ff <= 1'b0; tmo_ff <= '0;
         sess_ff <= '0; gen_ff <= '0; phys_ff <= '0; lphys_ff <= '0;
         lcnt_ff <= '0; fcnt_ff <= '0; lfilt_ff <= '0;
         anchor_ff <= '0; anchor_v_ff <= 1'b0; mode_ff <= 1'b1;
         valid_ff <= '0; head_ff <= '0; ptr_ff <= '0; clr_ff <= '0;
         left_ff <= '0; rd_v_ff <= 1'b0; key_v_ff <= 1'b0; hit_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.exec;
         if (csr_we) begin
            unique case (csr_idx)
               CSR_LPR: begin
                  if (csr_data[15:0] != lpr_ff) begin
                     lpr_ff <= csr_data[15:0];
                     phys_ff <= '0; lcnt_ff <= '0; fcnt_ff <= '0;
                     anchor_ff <= '0; anchor_v_ff <= 1'b0;
                     mode_ff <= (filt_ff == '0);
                     gen_ff <= gen_ff + 32'd1;
                     valid_ff <= '0; head_ff <= '0;
                  end
               end
               CSR_FILTER: begin
                  filt_ff <= csr_data[7:0];
                  if (phys_ff == '0) begin
                     mode_ff <= (csr_data[7:0] == '0);
                  end else begin
                     mode_ff <= !(fcnt_ff < csr_data[7:0]);
                  end
               end
               CSR_CNT_OFF: cnt_off_ff <= csr_data[0];
               CSR_TIMEOUT: tmo_ff <= csr_data[47:0];
               default: ;
            endcase
         end
         if (cmd.clr_step) begin
            valid_ff[clr_ff] <= 1'b0;
            clr_ff <= inc_ptr(clr_ff);
         end
         if (cmd.load) begin
            op_ff <= req_op; rsess_ff <= req_session;
            seq_ff <= req_trigger_seq; t_ff <= req_time_ns;
         end
         if (cmd.sess_clear) begin
            sess_ff <= rsess_ff; gen_ff <= '0; lphys_ff <= '0; lfilt_ff <= '0;
            phys_ff <= '0; lcnt_ff <= '0; fcnt_ff <= '0;
            anchor_ff <= '0; anchor_v_ff <= 1'b0; mode_ff <= (filt_ff == '0);
            valid_ff <= '0; head_ff <= '0;
         end
         if (cmd.scan_rst) begin
            // newest first, starting just before head
            ptr_ff  <= cmd.sess_clear ? LAST : dec_ptr(head_ff);
            left_ff <= CW'(CACHE_DEPTH);
            rd_v_ff <= 1'b0;
            hit_ff  <= 1'b0;
         end
         if (cmd.scan_step) begin
            rd_v_ff  <= (left_ff != '0);
            key_v_ff <= valid_ff[ptr_ff];
            if (left_ff != '0) begin
               left_ff <= left_ff - CW'(1);
               if (!cmd.hit_read) begin
                  ptr_ff <= dec_ptr(ptr_ff);
               end
            end
         end
         if (cmd.hit_read) begin
            hit_ff <= 1'b1;
            ptr_ff <= inc_ptr(ptr_ff); // back to the matching entry
         end
         if (cmd.exec) begin
            if (hit_ff) begin
               {rsp_round_generation, rsp_decision, rsp_logical_index,
                rsp_final_logical} <= dec_rd_ff;
               rsp_new_distinct   <= 1'b0;
               rsp_round_complete <= 1'b0;
               rsp_timeout_closed <= 1'b0;
               rsp_idle_ns        <= '0;
               rsp_completed_physical <= lphys_ff;
               rsp_completed_filtered <= lfilt_ff;
               rsp_round_state        <= mode_ff;
            end else begin
               gen_ff <= gen_n; phys_ff <= phys_n; lphys_ff <= lphys_n;
               lcnt_ff <= lcnt_n; fcnt_ff <= fcnt_n; lfilt_ff <= lfilt_n;
               anchor_ff <= anchor_n; anchor_v_ff <= anchor_v_n; mode_ff <= mode_n;
               rsp_round_generation <= gen_out;
               rsp_decision       <= dec_n;
               rsp_logical_index  <= (op_ff == OP_TIMEOUT) ? '0 : idx_n;
               rsp_new_distinct   <= (op_ff == OP_CLASSIFY);
               rsp_round_complete <= rc_n;
               rsp_final_logical  <= fin_n;
               rsp_timeout_closed <= tc_n;
               rsp_idle_ns        <= idle_n;
               rsp_completed_physical <= lphys_n;
               rsp_completed_filtered <= lfilt_n;
               rsp_round_state        <= mode_n;
               if (op_ff == OP_CLASSIFY) begin
                  valid_ff[head_ff] <= 1'b1;
                  head_ff <= inc_ptr(head_ff);
               end
            end
         end
      end
   end

endmodule

// ----- src/trigger_round_classifier.sv -----
// Flow: a timeout event goes CHECK then EXEC; a trigger goes CHECK, SCAN and EXEC on a miss,
// and CHECK, SCAN, READ and EXEC on a hit (scan stops at the newest match).
// Throughput: one word at a time; the next word is taken only in IDLE, which can be the
// cycle that presents the result. The cache scan reads one entry per cycle.
// Reset: synchronous; clears the config, round state and valid bits, then a pass clears
// the cache valid bits with busy high. The receiver cannot stall.
module trigger_round_classifier
   import trc_pkg::*;
#(
   parameter int CACHE_DEPTH = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [31:0] req_session,
   input  logic [15:0] req_trigger_seq,
   input  logic [62:0] req_time_ns,
   output logic        rsp_valid,
   output logic [31:0] rsp_round_generation,
   output logic        rsp_decision,
   output logic signed [16:0] rsp_logical_index,
   output logic        rsp_new_distinct,
   output logic        rsp_round_complete,
   output logic        rsp_final_logical,
   output logic        rsp_timeout_closed,
   output logic [62:0] rsp_idle_ns,
   output logic [31:0] rsp_completed_physical,
   output logic [7:0]  rsp_completed_filtered,
   output logic        rsp_round_state,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   trc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   trc_dp #(.CACHE_DEPTH(CACHE_DEPTH)) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_op                 (req_op),
      .req_session            (req_session),
      .req_trigger_seq        (req_trigger_seq),
      .req_time_ns            (req_time_ns),
      .csr_we                 (csr_valid && csr_ready),
      .csr_idx                (csr_index),
      .csr_data               (csr_wdata),
      .rsp_valid              (rsp_valid),
      .rsp_round_generation   (rsp_round_generation),
      .rsp_decision           (rsp_decision),
      .rsp_logical_index      (rsp_logical_index),
      .rsp_new_distinct       (rsp_new_distinct),
      .rsp_round_complete     (rsp_round_complete),
      .rsp_final_logical      (rsp_final_logical),
      .rsp_timeout_closed     (rsp_timeout_closed),
      .rsp_idle_ns            (rsp_idle_ns),
      .rsp_completed_physical (rsp_completed_physical),
      .rsp_completed_filtered (rsp_completed_filtered),
      .rsp_round_state        (rsp_round_state)
   );

`ifndef SYNTHESIS
   a_no_start_ack_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !(cmd.load)) else $error("word taken while busy");
   a_rsp_one_shot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held longer than one cycle");
   a_hit_not_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_round_complete |-> rsp_new_distinct && rsp_final_logical)
      else $error("count close without new trigger");
`endif

endmodule
